// ===== rtl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// shared types, constants and the mu-law encoder for the capture ring
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int BYTE_W       = 8;
    localparam int MAXB_W       = 7;
    localparam int LEVEL_W      = 16;
    localparam int DEPTH_DEF    = 32768;
    localparam int MAX_PULL_DEF = 64;

    localparam logic [16:0] MU_CLIP  = 17'd32635;
    localparam logic [14:0] MU_BIAS  = 15'h0084;
    localparam logic [3:0]  MU_MANT  = 4'hF;
    localparam logic [7:0]  MU_INV   = 8'hFF;
    localparam logic [7:0]  MU_SIGN  = 8'h80;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_PULL
    } ctrl_state_t;

    typedef struct packed {
        logic push;
        logic empty;
        logic rd;
        logic rd_first;
        logic rd_last;
    } mcr_cmd_t;

    typedef struct packed {
        logic take_zero;
        logic take_one;
        logic remain_one;
    } mcr_stat_t;

    function automatic logic [7:0] mulaw_encode(input logic [15:0] raw);
        logic        neg;
        logic [16:0] mag17;
        logic [14:0] mag;
        logic [2:0]  expo;
        logic        found;
        logic [14:0] shifted;
        logic [7:0]  code;
        neg   = raw[15];
        mag17 = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (mag17 > MU_CLIP)
            mag17 = MU_CLIP;
        mag   = mag17[14:0] + MU_BIAS;
        expo  = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 1; i--)
        begin
            if (!found && mag[i + 7])
            begin
                expo  = 3'(i);
                found = 1'b1;
            end
        end
        shifted = mag >> (4'(expo) + 4'd3);
        code    = (neg ? MU_SIGN : 8'h00) | {1'b0, expo, 4'h0}
                | {4'h0, shifted[3:0] & MU_MANT};
        return ~code & MU_INV;
    endfunction

endpackage

// ===== rtl/mcr_ram.sv =====
// ----------------------------------------------------------------------------
// mcr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcr_ctrl
// command sequencer: push, empty pull and byte-per-cycle pull
// ----------------------------------------------------------------------------
module mcr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               func,
    input  mcr_pkg::mcr_stat_t stat,
    output logic               busy,
    output mcr_pkg::mcr_cmd_t  cmd
);

    import mcr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_PUSH)
                        cmd.push = 1'b1;
                    else if (stat.take_zero)
                        cmd.empty = 1'b1;
                    else
                    begin
                        cmd.rd       = 1'b1;
                        cmd.rd_first = 1'b1;
                        cmd.rd_last  = stat.take_one;
                        if (!stat.take_one)
                            state_next = ST_PULL;
                    end
                end
            end
            ST_PULL:
            begin
                busy        = 1'b1;
                cmd.rd      = 1'b1;
                cmd.rd_last = stat.remain_one;
                if (stat.remain_one)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mcr_dp.sv =====
// ----------------------------------------------------------------------------
// mcr_dp
// ring pointers, fill count, encoder and result registers
// ----------------------------------------------------------------------------
module mcr_dp #(
    parameter int DEPTH    = mcr_pkg::DEPTH_DEF,
    parameter int MAX_PULL = mcr_pkg::MAX_PULL_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mcr_pkg::mcr_cmd_t                cmd,
    output mcr_pkg::mcr_stat_t               stat,
    input  logic signed [mcr_pkg::SAMPLE_W-1:0] sample,
    input  logic [mcr_pkg::MAXB_W-1:0]       max_bytes,
    output logic                             strobe,
    output logic [mcr_pkg::BYTE_W-1:0]       data_byte,
    output logic                             valid_res,
    output logic                             last,
    output logic                             dropped,
    output logic [mcr_pkg::LEVEL_W-1:0]      level
);

    import mcr_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MAXB_W) ? CW : MAXB_W;

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [MAXB_W-1:0]  remain_reg, remain_next;
    logic               strobe_reg, strobe_next;
    logic               valid_reg, valid_next;
    logic               last_reg, last_next;
    logic               drop_reg, drop_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [MAXB_W-1:0]  limit;
    logic [MAXB_W-1:0]  take;
    logic               full;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_inc;
    logic [BYTE_W-1:0]  code;
    logic [BYTE_W-1:0]  ram_q;

    assign limit    = (max_bytes > MAXB_W'(MAX_PULL)) ? MAXB_W'(MAX_PULL) : max_bytes;
    assign take     = (CMPW'(fill_reg) < CMPW'(limit)) ? MAXB_W'(fill_reg) : limit;
    assign full     = (fill_reg == CW'(DEPTH));
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign code     = mulaw_encode(sample);

    assign stat.take_zero  = (take == '0);
    assign stat.take_one   = (take == MAXB_W'(1));
    assign stat.remain_one = (remain_reg == MAXB_W'(1));

    mcr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (code),
        .re    (cmd.rd),
        .raddr (head_reg),
        .rdata (ram_q)
    );

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        strobe_next = 1'b0;
        valid_next  = 1'b0;
        last_next   = 1'b0;
        drop_next   = 1'b0;
        level_next  = level_reg;
        if (cmd.push)
        begin
            tail_next   = tail_inc;
            strobe_next = 1'b1;
            last_next   = 1'b1;
            if (full)
            begin
                head_next = head_inc;
                drop_next = 1'b1;
            end
            else
                fill_next = fill_reg + 1'b1;
            level_next = LEVEL_W'(fill_next);
        end
        else if (cmd.empty)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            level_next  = LEVEL_W'(fill_reg);
        end
        else if (cmd.rd)
        begin
            head_next   = head_inc;
            fill_next   = fill_reg - 1'b1;
            remain_next = cmd.rd_first ? take - 1'b1 : remain_reg - 1'b1;
            strobe_next = 1'b1;
            valid_next  = 1'b1;
            last_next   = cmd.rd_last;
            level_next  = LEVEL_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            drop_reg   <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            drop_reg   <= drop_next;
            level_reg  <= level_next;
        end
    end

    assign strobe    = strobe_reg;
    assign valid_res = valid_reg;
    assign last      = last_reg;
    assign dropped   = drop_reg;
    assign level     = level_reg;
    assign data_byte = valid_reg ? ram_q : '0;

endmodule

// ===== rtl/mulaw_capture_ring_core.sv =====
// ----------------------------------------------------------------------------
// mulaw_capture_ring_core
// mu-law capture ring: encodes pushed samples into a ring, pulls bytes out
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A push gives a single
// result, which strobes on the next cycle. A pull that takes n bytes reads one
// byte per cycle through the ring memory read port, holds busy while it reads
// the bytes after the first, and strobes each byte in the cycle after its read
// (an empty pull gives one not-valid result on the next cycle). Every result
// is on the outputs for exactly one cycle and cannot be held off. The ring
// memory is not cleared after reset; only bytes counted in the fill level are
// ever read back.
module mulaw_capture_ring_core #(
    parameter int DEPTH    = mcr_pkg::DEPTH_DEF,
    parameter int MAX_PULL = mcr_pkg::MAX_PULL_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic signed [mcr_pkg::SAMPLE_W-1:0] sample,
    input  logic [mcr_pkg::MAXB_W-1:0]          max_bytes,
    output logic                                strobe,
    output logic [mcr_pkg::BYTE_W-1:0]          data_byte,
    output logic                                valid_res,
    output logic                                last,
    output logic                                dropped,
    output logic [mcr_pkg::LEVEL_W-1:0]         level
);

    import mcr_pkg::*;

    mcr_cmd_t  cmd;
    mcr_stat_t stat;

    mcr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    mcr_dp #(
        .DEPTH    (DEPTH),
        .MAX_PULL (MAX_PULL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (sample),
        .max_bytes (max_bytes),
        .strobe    (strobe),
        .data_byte (data_byte),
        .valid_res (valid_res),
        .last      (last),
        .dropped   (dropped),
        .level     (level)
    );

`ifndef ASSERT_OFF
    a_busy_gives_byte: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (strobe && valid_res))
        else $error("pull cycle without a byte result");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_PUSH) |=> (strobe && !valid_res && last))
        else $error("push result malformed");

    a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !valid_res) |-> (last && data_byte == '0))
        else $error("not-valid result not marked last");

    a_pull_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && valid_res && !last) |=> (strobe && valid_res && !dropped))
        else $error("pull stream broken before last");
`endif

endmodule
